// File: sv/bplru_pkg.sv
// shared constants, codes and structs of the buffer pool lru tag manager
// used by every module of the block but bplru_ram; depends on nothing
`default_nettype none

package bplru_pkg;

	localparam int NUM_FRAMES = 64;
	localparam int IDX_W      = $clog2(NUM_FRAMES);
	localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

	localparam int FILE_W = 16;
	localparam int BLK_W  = 24;
	localparam int AGE_W  = 16;
	localparam int FIDX_W = 6;
	localparam int MEM_W  = FILE_W + BLK_W + AGE_W;

	localparam int IN_DATA_W  = ((FILE_W + BLK_W + FIDX_W + 1) + 7) / 8 * 8;
	localparam int OUT_DATA_W = ((FIDX_W + 3 + FILE_W + BLK_W + 1) + 7) / 8 * 8;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic [1:0] OP_FETCH  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_TOUCH  = 2'd2;
	localparam logic [1:0] OP_INVAL  = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [FILE_W-1:0] file_id;
		logic [BLK_W-1:0]  block_offset;
		logic [FIDX_W-1:0] frame_index;
		logic              avoid_same_file;
	} item_t;

	typedef struct packed {
		logic [FIDX_W-1:0] frame_out;
		logic              hit;
		logic              must_fill;
		logic              need_writeback;
		logic [FILE_W-1:0] victim_file_id;
		logic [BLK_W-1:0]  victim_block_offset;
		logic              status;
	} res_t;

	// one word of the tag memory
	typedef struct packed {
		logic [FILE_W-1:0] file;
		logic [BLK_W-1:0]  block;
		logic [AGE_W-1:0]  age;
	} mem_word_t;

	// one scanned frame, handed to the selector
	typedef struct packed {
		logic              clear;
		logic              en;
		logic              lookup;
		logic              avoid;
		logic [FILE_W-1:0] key_file;
		logic [BLK_W-1:0]  key_block;
		logic [IDX_W-1:0]  idx;
		logic              valid;
		logic [FILE_W-1:0] file;
		logic [BLK_W-1:0]  block;
		logic [AGE_W-1:0]  age;
	} scan_t;

	// what the selector found over one scan
	typedef struct packed {
		logic              hit_found;
		logic [IDX_W-1:0]  hit_idx;
		logic              inv_found;
		logic [IDX_W-1:0]  inv_idx;
		logic              best_found;
		logic [IDX_W-1:0]  best_idx;
		logic [FILE_W-1:0] best_file;
		logic [BLK_W-1:0]  best_block;
	} pick_t;

endpackage

`default_nettype wire

// File: sv/buffer_pool_lru_tag_manager.sv
// top level of the buffer pool lru tag manager: stream ports and result register
// depends on bplru_pkg, bplru_ctrl
`default_nettype none

// Tag manager for a pool of NUM_FRAMES buffer frames with least-recently-used
// replacement. Each request carries an opcode in s_tuser: fetch looks up
// (file_id, block_offset) and on a miss claims the first invalid frame, or
// else the oldest valid frame (optionally one of another file), reporting
// whether the old contents must be written back and the frame filled; append
// claims a frame for a new dirty block; touch marks a frame dirty, restarts
// its age and ages every other valid frame (ages saturate); invalidate
// drops all frames of a file. Exactly one result comes back per request,
// in order. File, block and age of every frame sit in one single-port-read
// tag memory; valid and dirty bits are flops and are cleared by reset, so the
// block is ready right after reset with no clearing pass. Every request
// except a touch of an invalid or out of range frame sweeps the tag memory
// one frame per clock. Requests are taken one at a time, but a new request
// is accepted while the previous result still waits in the output register.

module buffer_pool_lru_tag_manager import bplru_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// file_id[15:0], block_offset[39:16], frame_index[45:40], avoid_same_file[46], zero pad
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// frame_out[5:0], hit[6], must_fill[7], need_writeback[8], victim_file_id[24:9],
	// victim_block_offset[48:25], status[49], zero pad
	output logic      [OUT_DATA_W-1:0] m_tdata
);

	localparam int PAD_W = OUT_DATA_W - (FIDX_W + 3 + FILE_W + BLK_W + 1);

	item_t in_item;
	logic  res_valid;
	logic  res_ready;
	res_t  res;
	logic  load;
	logic  m_tvalid_q;
	res_t  out_q;

	// unpack the request
	always_comb begin
		in_item.opcode          = s_tuser;
		in_item.file_id         = s_tdata[15:0];
		in_item.block_offset    = s_tdata[39:16];
		in_item.frame_index     = s_tdata[45:40];
		in_item.avoid_same_file = s_tdata[46];
	end

	bplru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register, refilled when empty or drained in the same cycle
	assign res_ready = !m_tvalid_q || m_tready;
	assign load      = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_q.status, out_q.victim_block_offset,
		out_q.victim_file_id, out_q.need_writeback, out_q.must_fill, out_q.hit,
		out_q.frame_out};

endmodule

`default_nettype wire

// File: sv/bplru_ram.sv
// simple dual port tag memory, one write and one registered read per cycle
// generic; depends on nothing
`default_nettype none

module bplru_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 56,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/bplru_pick.sv
// running selector over a frame scan: first hit, first invalid frame, oldest eligible frame
// depends on bplru_pkg
`default_nettype none

module bplru_pick import bplru_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire scan_t scan,
	output pick_t      pick
);

	pick_t            pick_q;
	logic [AGE_W-1:0] best_age_q;
	logic             key_match;
	logic             hit_now;
	logic             elig;
	logic             better;

	always_comb begin
		key_match = (scan.file == scan.key_file);
		hit_now   = scan.lookup && scan.valid && key_match && (scan.block == scan.key_block);
		elig      = scan.valid && !(scan.avoid && key_match);
		// strict compare keeps the lowest index on equal ages
		better    = elig && (!pick_q.best_found || (scan.age > best_age_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_q     <= '0;
			best_age_q <= '0;
		end else if (scan.clear) begin
			pick_q.hit_found  <= 1'b0;
			pick_q.inv_found  <= 1'b0;
			pick_q.best_found <= 1'b0;
		end else if (scan.en) begin
			if (hit_now && !pick_q.hit_found) begin
				pick_q.hit_found <= 1'b1;
				pick_q.hit_idx   <= scan.idx;
			end
			if (!scan.valid && !pick_q.inv_found) begin
				pick_q.inv_found <= 1'b1;
				pick_q.inv_idx   <= scan.idx;
			end
			if (better) begin
				pick_q.best_found <= 1'b1;
				pick_q.best_idx   <= scan.idx;
				pick_q.best_file  <= scan.file;
				pick_q.best_block <= scan.block;
				best_age_q        <= scan.age;
			end
		end
	end

	assign pick = pick_q;

endmodule

`default_nettype wire

// File: sv/bplru_ctrl.sv
// request sequencer: scans the tag memory one frame per cycle and writes back
// depends on bplru_pkg, bplru_ram, bplru_pick
`default_nettype none

module bplru_ctrl import bplru_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t in_item,
	output logic       res_valid,
	input  wire logic  res_ready,
	output res_t       res
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]            state_q;
	item_t                 item_q;
	res_t                  res_q;
	logic [CNT_W-1:0]      issue_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [NUM_FRAMES-1:0] valid_q;
	logic [NUM_FRAMES-1:0] dirty_q;

	logic                  accept;
	logic                  in_tgt_ok;
	logic [IDX_W-1:0]      in_tidx;
	logic [IDX_W-1:0]      tidx;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [MEM_W-1:0]      rd_data;
	mem_word_t             rword;
	logic                  scan_v;
	logic                  proc;
	logic                  scan_end;
	logic                  is_alloc;
	logic                  touch_wr;
	logic [AGE_W-1:0]      new_age;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	mem_word_t             wr_word;
	scan_t                 scan;
	pick_t                 pick;
	logic                  victim_ok;
	logic [IDX_W-1:0]      victim_idx;
	logic                  claim;
	res_t                  dec_res;
	res_t                  start_res;

	bplru_ram #(.DEPTH(NUM_FRAMES), .WIDTH(MEM_W)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bplru_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan),
		.pick   (pick)
	);

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		accept    = in_valid && in_ready;
		in_tidx   = IDX_W'(in_item.frame_index);
		in_tgt_ok = (32'(in_item.frame_index) < 32'(NUM_FRAMES)) && valid_q[in_tidx];
		tidx      = IDX_W'(item_q.frame_index);
		is_alloc  = (item_q.opcode == OP_FETCH) || (item_q.opcode == OP_APPEND);

		rd_en    = (state_q == ST_SCAN) && (issue_q < CNT_W'(NUM_FRAMES));
		rd_addr  = issue_q[IDX_W-1:0];
		rword    = mem_word_t'(rd_data);
		scan_v   = valid_q[idx_s1];
		proc     = vld_s1 && (state_q == ST_SCAN);
		scan_end = (state_q == ST_SCAN) && !rd_en && !vld_s1;

		// saturating age step, the touched frame restarts at zero
		if (idx_s1 == tidx) begin
			new_age = '0;
		end else if (rword.age == AGE_MAX) begin
			new_age = rword.age;
		end else begin
			new_age = rword.age + AGE_W'(1);
		end
		touch_wr = proc && (item_q.opcode == OP_TOUCH) && scan_v;

		scan.clear     = accept;
		scan.en        = proc && is_alloc;
		scan.lookup    = (item_q.opcode == OP_FETCH);
		scan.avoid     = (item_q.opcode == OP_FETCH) && item_q.avoid_same_file;
		scan.key_file  = item_q.file_id;
		scan.key_block = item_q.block_offset;
		scan.idx       = idx_s1;
		scan.valid     = scan_v;
		scan.file      = rword.file;
		scan.block     = rword.block;
		scan.age       = rword.age;

		victim_ok  = pick.inv_found || pick.best_found;
		victim_idx = pick.inv_found ? pick.inv_idx : pick.best_idx;
		claim      = (state_q == ST_DECIDE) && !pick.hit_found && victim_ok;

		dec_res = '0;
		if (pick.hit_found) begin
			dec_res.frame_out = FIDX_W'(pick.hit_idx);
			dec_res.hit       = 1'b1;
		end else if (!victim_ok) begin
			dec_res.status = 1'b1;
		end else begin
			dec_res.frame_out = FIDX_W'(victim_idx);
			dec_res.must_fill = (item_q.opcode == OP_FETCH);
			// an invalid victim is always clean
			if (!pick.inv_found && dirty_q[pick.best_idx]) begin
				dec_res.need_writeback      = 1'b1;
				dec_res.victim_file_id      = pick.best_file;
				dec_res.victim_block_offset = pick.best_block;
			end
		end

		start_res = '0;
		if (in_item.opcode == OP_TOUCH) begin
			start_res.frame_out = in_item.frame_index;
		end

		if (claim) begin
			wr_en         = 1'b1;
			wr_addr       = victim_idx;
			wr_word.file  = item_q.file_id;
			wr_word.block = item_q.block_offset;
			wr_word.age   = '0;
		end else begin
			wr_en         = touch_wr;
			wr_addr       = idx_s1;
			wr_word.file  = rword.file;
			wr_word.block = rword.block;
			wr_word.age   = new_age;
		end

		res_valid = (state_q == ST_DONE);
		res       = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= '0;
			vld_s1  <= 1'b0;
			valid_q <= '0;
			dirty_q <= '0;
		end else begin
			vld_s1 <= rd_en;
			if (rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						issue_q <= '0;
						if (in_item.opcode == OP_TOUCH) begin
							if (in_tgt_ok) begin
								dirty_q[in_tidx] <= 1'b1;
								state_q          <= ST_SCAN;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (proc && (item_q.opcode == OP_INVAL) && scan_v
							&& (rword.file == item_q.file_id)) begin
						valid_q[idx_s1] <= 1'b0;
						dirty_q[idx_s1] <= 1'b0;
					end
					if (scan_end) begin
						state_q <= is_alloc ? ST_DECIDE : ST_DONE;
					end
				end
				ST_DECIDE: begin
					if (claim) begin
						valid_q[victim_idx] <= 1'b1;
						dirty_q[victim_idx] <= (item_q.opcode == OP_APPEND);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_addr;
		end
		if (accept) begin
			item_q <= in_item;
			res_q  <= start_res;
		end else if (state_q == ST_DECIDE) begin
			res_q <= dec_res;
		end
	end

endmodule

`default_nettype wire
